// ===== rtl/stt_pkg.sv =====
// Shared types, constants and helper functions of the source text tokenizer.
package stt_pkg;

  localparam int LINE_BITS = 16;
  localparam int QDEPTH    = 4;   // Bundle queue depth, a power of two.
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int MAX_RES   = 3;

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_ZERO   = 8'h00;

  typedef enum logic [2:0] {
    CL_INT   = 3'd0,
    CL_DEC   = 3'd1,
    CL_DOT   = 3'd2,
    CL_IDENT = 3'd3,
    CL_OP    = 3'd4,
    CL_STR   = 3'd5,
    CL_ESC   = 3'd6,
    CL_WS    = 3'd7
  } tok_class_t;

  typedef enum logic [1:0] {
    EV_TEXT    = 2'd0,
    EV_END     = 2'd1,
    EV_ESC_ERR = 2'd2
  } event_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  text_byte;
    logic [2:0]  token_type;
    logic [15:0] line_number;
    logic        last_of_run;
  } event_item_t;

  typedef struct packed {
    logic [1:0]                count;
    event_item_t [MAX_RES-1:0] res;
  } bundle_t;

  typedef struct packed {
    logic    nonempty;
    bundle_t head;
  } q_head_t;

  function automatic logic is_op_char(input logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAREN) ||
           (c == CH_RPAREN) || (c == CH_EQUAL) || (c == CH_MINUS) ||
           (c == CH_COLON) || (c == CH_COMMA) || (c == CH_SEMI);
  endfunction

  function automatic event_item_t make_event(input event_t kind, input logic [7:0] b,
                                             input tok_class_t cls,
                                             input logic [LINE_BITS-1:0] ln);
    event_item_t e;
    e.event_res   = kind;
    e.text_byte   = b;
    e.token_type  = cls;
    e.line_number = 16'(ln);
    e.last_of_run = 1'b0;
    return e;
  endfunction

endpackage

// ===== rtl/stt_front.sv =====
// Front end: accepts source bytes, tracks token class and line, builds result bundles.
module stt_front import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  text_item_t text_item,
  input  logic       q_full,
  output logic       push,
  output bundle_t    push_bundle
);

  tok_class_t           token_class;
  tok_class_t           token_class_next;
  logic [LINE_BITS-1:0] line_count;
  logic [LINE_BITS-1:0] line_count_next;
  logic                 accept;

  assign text_stall = q_full;
  assign accept     = text_valid && !q_full;

  always_comb begin
    logic [7:0]  c;
    logic        eot;
    tok_class_t  cur;
    tok_class_t  cls_new;
    tok_class_t  post_cls;
    logic        pre_end;
    logic        do_app;
    logic [7:0]  app_byte;
    logic        do_err;
    logic        op_end;
    logic        post_end;
    logic        line_inc;
    logic [1:0]  n;
    bundle_t     b;

    c        = text_item.ch;
    eot      = text_item.end_of_text;
    cur      = token_class;
    cls_new  = cur;
    pre_end  = 1'b0;
    do_app   = 1'b0;
    app_byte = c;
    do_err   = 1'b0;
    op_end   = 1'b0;
    line_inc = 1'b0;

    priority if (cur == CL_ESC) begin
      cls_new = CL_STR;
      do_app  = 1'b1;
      priority if (c == CH_LOW_N) begin
        app_byte = CH_LF;
      end else if (c == CH_LOW_T) begin
        app_byte = CH_TAB;
      end else if (c == CH_LOW_R) begin
        app_byte = CH_CR;
      end else if (c == CH_BSLASH) begin
        app_byte = CH_BSLASH;
      end else begin
        do_app = 1'b0;
        do_err = 1'b1;
      end
    end else if (c >= CH_0 && c <= CH_9) begin
      if (cur == CL_WS) begin
        cls_new = CL_INT;
      end
      do_app = 1'b1;
    end else if (c == CH_DOT) begin
      priority if (cur == CL_WS) begin
        cls_new = CL_DOT;
        do_app  = 1'b1;
      end else if (cur == CL_INT) begin
        cls_new = CL_DEC;
        do_app  = 1'b1;
      end else if (cur == CL_STR) begin
        do_app = 1'b1;
      end else begin
        op_end = 1'b1;
      end
    end else if (is_op_char(c)) begin
      if (cur == CL_STR) begin
        do_app = 1'b1;
      end else begin
        op_end = 1'b1;
      end
    end else if (c == CH_SPACE || c == CH_TAB) begin
      if (cur == CL_STR) begin
        do_app = 1'b1;
      end else begin
        pre_end = 1'b1;
        cls_new = CL_WS;
      end
    end else if (c == CH_CR || c == CH_LF) begin
      pre_end  = 1'b1;
      cls_new  = CL_WS;
      line_inc = 1'b1;
    end else if (c == CH_QUOTE) begin
      pre_end = 1'b1;
      cls_new = (cur == CL_STR) ? CL_WS : CL_STR;
    end else if (c == CH_BSLASH) begin
      if (cur == CL_STR) begin
        cls_new = CL_ESC;
      end else begin
        op_end = 1'b1;
      end
    end else begin
      if (cur == CL_WS || cur == CL_INT || cur == CL_DEC) begin
        pre_end = 1'b1;
        cls_new = CL_IDENT;
      end
      do_app = 1'b1;
    end

    // An operator closes any open token, then forms a token of its own.
    if (op_end) begin
      pre_end = 1'b1;
      cls_new = CL_OP;
      do_app  = 1'b1;
    end

    post_end = op_end || (eot && cls_new != CL_WS);
    post_cls = (cls_new == CL_ESC) ? CL_STR : cls_new;

    n = 2'd0;
    b = '0;
    if (pre_end && cur != CL_WS) begin
      b.res[n] = make_event(EV_END, CH_ZERO, cur, line_count);
      n        = n + 2'd1;
    end
    if (do_app) begin
      b.res[n] = make_event(EV_TEXT, app_byte, cls_new, line_count);
      n        = n + 2'd1;
    end
    if (do_err) begin
      b.res[n] = make_event(EV_ESC_ERR, c, CL_STR, line_count);
      n        = n + 2'd1;
    end
    if (post_end) begin
      b.res[n] = make_event(EV_END, CH_ZERO, post_cls, line_count);
      n        = n + 2'd1;
    end
    if (n != 2'd0) begin
      b.res[n - 2'd1].last_of_run = 1'b1;
    end
    b.count     = n;
    push_bundle = b;
    push        = accept && (n != 2'd0);

    if (eot) begin
      token_class_next = CL_WS;
      line_count_next  = LINE_ONE;
    end else begin
      token_class_next = op_end ? CL_WS : cls_new;
      line_count_next  = (line_inc && line_count != LINE_MAX) ? line_count + LINE_ONE
                                                               : line_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_class <= CL_WS;
      line_count  <= LINE_ONE;
    end else if (accept) begin
      token_class <= token_class_next;
      line_count  <= line_count_next;
    end
  end

endmodule

// ===== rtl/stt_queue.sv =====
// Short queue of result bundles between the front end and the output stage.
module stt_queue import stt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_bundle,
  input  logic    pop,
  output logic    full,
  output q_head_t q_head
);

  bundle_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full            = (fill == (QPTR_W+1)'(QDEPTH));
  assign q_head.nonempty = (fill != '0);
  assign q_head.head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + (QPTR_W+1)'(1);
        2'b01:   fill <= fill - (QPTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/stt_back.sv =====
// Output stage: serialises each bundle into single results through an output register.
module stt_back import stt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  q_head_t     q_head,
  output logic        pop,
  output logic        event_valid,
  input  logic        event_stall,
  output event_item_t event_item
);

  logic [1:0] idx;
  logic       load;
  logic       last;

  assign load = !event_valid || !event_stall;
  assign last = (idx == q_head.head.count - 2'd1);
  assign pop  = load && q_head.nonempty && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
      idx         <= 2'd0;
    end else if (load) begin
      event_valid <= q_head.nonempty;
      if (q_head.nonempty) begin
        event_item <= q_head.head.res[idx];
        idx        <= last ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/source_text_tokenizer_top.sv =====
// Top level of the source text tokenizer.
//
// Source bytes arrive on the text channel (text_valid, text_stall, text_item) and
// token events leave on the event channel (event_valid, event_stall, event_item).
// Each event is a token text byte, a token end record with class and line, or an
// unknown escape error; last_of_run marks the final event caused by one byte.
// The front end takes one byte per cycle while text_stall is low and turns it into
// a bundle of zero to three events, which enters a four-entry bundle queue in the
// same cycle. The output register emits one event per cycle while event_stall is
// low. Bytes that cause one event or none flow at one byte per cycle while
// event_stall is low; an operator that closes an open token yields three events,
// and the queue absorbs such bursts. text_stall rises only when the queue is full,
// which happens when event_stall holds the output register or operator bursts
// arrive faster than they drain. A stalled event stays unchanged. Synchronous
// reset empties the queue and the output register, sets the token class to
// whitespace and the line counter to 1. A byte with end_of_text set flushes the
// open token and returns the state to its reset values.
module source_text_tokenizer_top import stt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  text_item_t  text_item,
  output logic        event_valid,
  input  logic        event_stall,
  output event_item_t event_item
);

  logic    push;
  bundle_t push_bundle;
  logic    pop;
  logic    q_full;
  q_head_t q_head;

  stt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_item   (text_item),
    .q_full      (q_full),
    .push        (push),
    .push_bundle (push_bundle)
  );

  stt_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (push_bundle),
    .pop         (pop),
    .full        (q_full),
    .q_head      (q_head)
  );

  stt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_head      (q_head),
    .pop         (pop),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_item  (event_item)
  );

endmodule

// ===== rtl/stt_checker.sv =====
// Port-level checker of the source text tokenizer and its binding to the top level.
module stt_checker import stt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        event_valid,
  input logic        event_stall,
  input event_item_t event_item
);

  // A stalled event must hold its valid and its payload.
  assert property (@(posedge clk) disable iff (rst)
    event_valid && event_stall |=> event_valid && $stable(event_item))
    else $error("stalled event changed");

  assert property (@(posedge clk) rst |=> !event_valid)
    else $error("event valid after reset");

  assert property (@(posedge clk) disable iff (rst)
    event_valid && event_item.event_res == EV_END |-> event_item.text_byte == CH_ZERO)
    else $error("token end record carries a text byte");

  assert property (@(posedge clk) disable iff (rst)
    event_valid && event_item.event_res == EV_ESC_ERR |->
      event_item.token_type == CL_STR)
    else $error("escape error outside a string");

  assert property (@(posedge clk) disable iff (rst)
    event_valid |-> event_item.line_number != 16'd0 &&
      event_item.token_type != CL_ESC && event_item.token_type != CL_WS)
    else $error("event with invalid line number or class");

endmodule

bind source_text_tokenizer_top stt_checker u_stt_checker (
  .clk         (clk),
  .rst         (rst),
  .event_valid (event_valid),
  .event_stall (event_stall),
  .event_item  (event_item)
);
